// File: hw/rtl/rsa_key_pair_enumerator_assert.svh
// assertion macros for the key pair enumerator
`ifndef RSA_KEY_PAIR_ENUMERATOR_ASSERT_SVH
`define RSA_KEY_PAIR_ENUMERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define RKE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rke assertion failed");
`define RKE_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rke forbidden condition seen");
`else
`define RKE_ASSERT(lbl, clk, rst_n, prop)
`define RKE_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: hw/rtl/rke_pkg.sv
`default_nettype none
package rke_pkg;
  localparam int PRIME_WIDTH_DEF = 16;
  localparam int MAX_PAIRS_DEF   = 64;
  localparam int IN_W            = 16;
  localparam int OUT_W           = 32;

  typedef logic [1:0] status_t;
  localparam status_t ST_PAIR = 2'd0;
  localparam status_t ST_BAD  = 2'd1;
  localparam status_t ST_NONE = 2'd2;
endpackage
`default_nettype wire

// File: hw/rtl/rke_div.sv
`default_nettype none
module rke_div #(
  parameter int W = 2 * rke_pkg::PRIME_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);
  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

// File: hw/rtl/rsa_key_pair_enumerator.sv
`default_nettype none
// rsa key pair enumerator
// request: pulse start with in_first_prime/in_second_prime while busy is low;
// busy stays high until the run ends. each prime uses its low PRIME_WIDTH bits.
// results leave on out_* with out_valid high for exactly one cycle each; the
// receiver cannot stall, so every result is taken in that cycle.
// a run gives one result per kept (e, d) pair in ascending e, up to MAX_PAIRS,
// the final one with out_last set; bad primes give one status-1 result, a run
// without any pair one status-2 result.
// latency is data dependent and set by the shared restoring divider, one
// quotient bit per cycle: trial division of p and q (about sqrt(x) divisions
// each), then per candidate e below the totient one division, plus a
// trial-division prime test when e neither divides the totient nor equals p
// or q, plus modular stepping for each kept e. a pair is shown when the next
// pair is found, the last one when the walk ends.
// reset (synchronous, rst_n low) returns the sequencer to idle and drops any
// pending result; no result is produced after reset until a new request.
module rsa_key_pair_enumerator #(
  parameter int MAX_PAIRS   = rke_pkg::MAX_PAIRS_DEF,
  parameter int PRIME_WIDTH = rke_pkg::PRIME_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [rke_pkg::IN_W-1:0]   in_first_prime,
  input  wire logic [rke_pkg::IN_W-1:0]   in_second_prime,
  output logic                            out_valid,
  output logic [rke_pkg::OUT_W-1:0]       out_modulus,
  output logic [rke_pkg::OUT_W-1:0]       out_enc_exponent,
  output logic [rke_pkg::OUT_W-1:0]       out_dec_exponent,
  output rke_pkg::status_t                out_status,
  output logic                            out_last
);
  import rke_pkg::*;

  localparam int PW = PRIME_WIDTH;
  localparam int TW = 2 * PRIME_WIDTH;
  localparam int CW = $clog2(MAX_PAIRS + 1);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_PT        = 9'b000000010,
    S_PT_WAIT   = 9'b000000100,
    S_MUL_N     = 9'b000001000,
    S_MUL_T     = 9'b000010000,
    S_CAND      = 9'b000100000,
    S_CAND_WAIT = 9'b001000000,
    S_INV       = 9'b010000000,
    S_FIN       = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    PH_P = 3'b001,
    PH_Q = 3'b010,
    PH_C = 3'b100
  } phase_t;

  state_t        state_r, state_nxt;
  phase_t        phase_r, phase_nxt;
  logic [PW-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [TW-1:0] n_r, n_nxt, t_r, t_nxt, c_r, c_nxt;
  logic [TW-1:0] qt_r, qt_nxt, rr_r, rr_nxt;
  logic [TW-1:0] x_r, x_nxt, dv_r, dv_nxt;
  logic [TW:0]   sq_r, sq_nxt;
  logic [TW-1:0] acc_r, acc_nxt, d_r, d_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [TW-1:0] pend_e_r, pend_e_nxt, pend_d_r, pend_d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic             ov_r, ov_nxt;
  logic [OUT_W-1:0] om_r, om_nxt, oe_r, oe_nxt, od_r, od_nxt;
  status_t          os_r, os_nxt;
  logic             ol_r, ol_nxt;

  logic          div_go, div_done;
  logic [TW-1:0] div_a, div_b, div_q, div_rem;

  logic [PW-1:0] mul_a, mul_b;
  logic [TW-1:0] prod;

  logic          pt_done, pt_prime;
  logic [TW:0]   inv_sum;
  logic          inv_wrap;
  logic [TW-1:0] inv_acc;
  logic [TW-1:0] inv_d;

  rke_div #(.W(TW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign mul_a = (state_r == S_MUL_N) ? p_r : p_r - PW'(1);
  assign mul_b = (state_r == S_MUL_N) ? q_r : q_r - PW'(1);
  assign prod  = {{PW{1'b0}}, mul_a} * {{PW{1'b0}}, mul_b};

  assign inv_sum  = {1'b0, acc_r} + {1'b0, rr_r};
  assign inv_wrap = inv_sum >= {1'b0, c_r};
  assign inv_acc  = inv_wrap ? TW'(inv_sum - {1'b0, c_r}) : inv_sum[TW-1:0];
  assign inv_d    = d_r + qt_r + TW'(inv_wrap);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    p_nxt      = p_r;
    q_nxt      = q_r;
    n_nxt      = n_r;
    t_nxt      = t_r;
    c_nxt      = c_r;
    qt_nxt     = qt_r;
    rr_nxt     = rr_r;
    x_nxt      = x_r;
    dv_nxt     = dv_r;
    sq_nxt     = sq_r;
    acc_nxt    = acc_r;
    d_nxt      = d_r;
    pend_v_nxt = pend_v_r;
    pend_e_nxt = pend_e_r;
    pend_d_nxt = pend_d_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = 1'b0;
    om_nxt     = om_r;
    oe_nxt     = oe_r;
    od_nxt     = od_r;
    os_nxt     = os_r;
    ol_nxt     = ol_r;
    div_go     = 1'b0;
    div_a      = x_r;
    div_b      = dv_r;
    pt_done    = 1'b0;
    pt_prime   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          p_nxt      = PW'(in_first_prime);
          q_nxt      = PW'(in_second_prime);
          x_nxt      = TW'(PW'(in_first_prime));
          dv_nxt     = TW'(2);
          sq_nxt     = (TW+1)'(4);
          phase_nxt  = PH_P;
          pend_v_nxt = 1'b0;
          cnt_nxt    = '0;
          state_nxt  = S_PT;
        end
      end
      S_PT: begin
        if (x_r < TW'(2)) begin
          pt_done = 1'b1;
        end else if (sq_r > {1'b0, x_r}) begin
          pt_done  = 1'b1;
          pt_prime = 1'b1;
        end else begin
          div_go    = 1'b1;
          state_nxt = S_PT_WAIT;
        end
      end
      S_PT_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            pt_done = 1'b1;
          end else begin
            sq_nxt    = sq_r + {dv_r, 1'b1};
            dv_nxt    = dv_r + TW'(1);
            state_nxt = S_PT;
          end
        end
      end
      S_MUL_N: begin
        n_nxt     = prod;
        state_nxt = S_MUL_T;
      end
      S_MUL_T: begin
        t_nxt     = prod;
        c_nxt     = TW'(2);
        state_nxt = S_CAND;
      end
      S_CAND: begin
        div_a = t_r;
        div_b = c_r;
        if (c_r >= t_r || cnt_r == CW'(MAX_PAIRS)) begin
          state_nxt = S_FIN;
        end else begin
          div_go    = 1'b1;
          state_nxt = S_CAND_WAIT;
        end
      end
      S_CAND_WAIT: begin
        if (div_done) begin
          qt_nxt = div_q;
          rr_nxt = div_rem;
          if (div_rem == '0 || c_r == TW'(p_r) || c_r == TW'(q_r)) begin
            c_nxt     = c_r + TW'(1);
            state_nxt = S_CAND;
          end else begin
            x_nxt     = c_r;
            dv_nxt    = TW'(2);
            sq_nxt    = (TW+1)'(4);
            phase_nxt = PH_C;
            state_nxt = S_PT;
          end
        end
      end
      S_INV: begin
        acc_nxt = inv_acc;
        d_nxt   = inv_d;
        if (inv_acc == '0) begin
          if (pend_v_r) begin
            ov_nxt = 1'b1;
            om_nxt = OUT_W'(n_r);
            oe_nxt = OUT_W'(pend_e_r);
            od_nxt = OUT_W'(pend_d_r);
            os_nxt = ST_PAIR;
            ol_nxt = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pend_e_nxt = c_r;
          pend_d_nxt = inv_d;
          cnt_nxt    = cnt_r + CW'(1);
          c_nxt      = c_r + TW'(1);
          state_nxt  = S_CAND;
        end
      end
      S_FIN: begin
        ov_nxt = 1'b1;
        om_nxt = OUT_W'(n_r);
        ol_nxt = 1'b1;
        if (pend_v_r) begin
          oe_nxt = OUT_W'(pend_e_r);
          od_nxt = OUT_W'(pend_d_r);
          os_nxt = ST_PAIR;
        end else begin
          oe_nxt = '0;
          od_nxt = '0;
          os_nxt = ST_NONE;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (pt_done) begin
      unique case (phase_r)
        PH_P: begin
          if (pt_prime) begin
            x_nxt     = TW'(q_r);
            dv_nxt    = TW'(2);
            sq_nxt    = (TW+1)'(4);
            phase_nxt = PH_Q;
            state_nxt = S_PT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
        PH_Q: begin
          if (pt_prime && p_r != q_r) begin
            state_nxt = S_MUL_N;
          end else begin
            state_nxt = S_IDLE;
          end
        end
        PH_C: begin
          if (pt_prime) begin
            acc_nxt   = TW'(1);
            d_nxt     = '0;
            state_nxt = S_INV;
          end else begin
            c_nxt     = c_r + TW'(1);
            state_nxt = S_CAND;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
      if ((phase_r == PH_P && !pt_prime) ||
          (phase_r == PH_Q && !(pt_prime && p_r != q_r))) begin
        ov_nxt = 1'b1;
        om_nxt = '0;
        oe_nxt = '0;
        od_nxt = '0;
        os_nxt = ST_BAD;
        ol_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_P;
      pend_v_r <= 1'b0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      pend_v_r <= pend_v_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
    end
    p_r      <= p_nxt;
    q_r      <= q_nxt;
    n_r      <= n_nxt;
    t_r      <= t_nxt;
    c_r      <= c_nxt;
    qt_r     <= qt_nxt;
    rr_r     <= rr_nxt;
    x_r      <= x_nxt;
    dv_r     <= dv_nxt;
    sq_r     <= sq_nxt;
    acc_r    <= acc_nxt;
    d_r      <= d_nxt;
    pend_e_r <= pend_e_nxt;
    pend_d_r <= pend_d_nxt;
    om_r     <= om_nxt;
    oe_r     <= oe_nxt;
    od_r     <= od_nxt;
    os_r     <= os_nxt;
    ol_r     <= ol_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_modulus      = om_r;
  assign out_enc_exponent = oe_r;
  assign out_dec_exponent = od_r;
  assign out_status       = os_r;
  assign out_last         = ol_r;

`include "rsa_key_pair_enumerator_assert.svh"
  `RKE_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> busy)
  `RKE_ASSERT(a_last_idle, clk, rst_n, (out_valid && out_last) |-> !busy)
  `RKE_ASSERT(a_mid_busy, clk, rst_n, (out_valid && !out_last) |-> busy)
  `RKE_NEVER(a_status_exp, clk, rst_n, out_valid && out_status != ST_PAIR && |out_enc_exponent)
  `RKE_NEVER(a_pair_limit, clk, rst_n, cnt_r > CW'(MAX_PAIRS))
endmodule
`default_nettype wire

// File: tb/rke_checker.sv
module rke_checker #(
  parameter int MAX_PAIRS   = rke_pkg::MAX_PAIRS_DEF,
  parameter int PRIME_WIDTH = rke_pkg::PRIME_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [rke_pkg::IN_W-1:0]     in_first_prime,
  input  logic [rke_pkg::IN_W-1:0]     in_second_prime,
  input  logic                         out_valid,
  input  logic [rke_pkg::OUT_W-1:0]    out_modulus,
  input  logic [rke_pkg::OUT_W-1:0]    out_enc_exponent,
  input  logic [rke_pkg::OUT_W-1:0]    out_dec_exponent,
  input  rke_pkg::status_t             out_status,
  input  logic                         out_last,
  output int                           fail_count,
  output int                           pending_keys,
  output int                           keys_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import rke_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] modulus;
    logic [OUT_W-1:0] enc_exp;
    logic [OUT_W-1:0] dec_exp;
    status_t          status;
    logic             last;
  } key_result_t;

  key_result_t key_q[$];

  function automatic bit is_prime(longint unsigned x);
    longint unsigned dv;
    if (x < 2) return 0;
    for (dv = 2; dv * dv <= x; dv++) begin
      if (x % dv == 0) return 0;
    end
    return 1;
  endfunction

  function automatic longint unsigned mod_inverse(longint unsigned e, longint unsigned t);
    longint unsigned r, acc, m;
    r = t % e;
    acc = 1 % e;
    m = 0;
    do begin
      m++;
      acc = (acc + r) % e;
    end while (acc != 0 && m <= e);
    return m * (t / e) + (m * r + 1) / e;
  endfunction

  task automatic predict_keys(logic [IN_W-1:0] a, logic [IN_W-1:0] b);
    longint unsigned pmask, p, q, n, t, c;
    int cnt;
    key_result_t r;
    pmask = (64'd1 << PRIME_WIDTH) - 1;
    p = a & pmask;
    q = b & pmask;
    cnt = 0;
    if (!is_prime(p) || !is_prime(q) || p == q) begin
      r = '{modulus: '0, enc_exp: '0, dec_exp: '0, status: ST_BAD, last: 1'b1};
      key_q.push_back(r);
    end else begin
      n = p * q;
      t = (p - 1) * (q - 1);
      for (c = 2; c < t && cnt < MAX_PAIRS; c++) begin
        if (t % c == 0) continue;
        if (c == p || c == q || !is_prime(c)) continue;
        r = '{modulus: n[OUT_W-1:0], enc_exp: c[OUT_W-1:0],
              dec_exp: OUT_W'(mod_inverse(c, t)), status: ST_PAIR, last: 1'b0};
        key_q.push_back(r);
        cnt++;
      end
      if (cnt == 0) begin
        r = '{modulus: n[OUT_W-1:0], enc_exp: '0, dec_exp: '0, status: ST_NONE, last: 1'b1};
        key_q.push_back(r);
      end else begin
        key_q[key_q.size()-1].last = 1'b1;
      end
    end
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    keys_seen = 0;
    pending_keys = 0;
  end

  always @(posedge clk) begin
    key_result_t want;
    if (rst_n) begin
      if (start && !busy) predict_keys(in_first_prime, in_second_prime);
      if (out_valid) begin
        keys_seen++;
        if (key_q.size() == 0) begin
          report("unexpected result", out_enc_exponent, 0);
        end else begin
          want = key_q.pop_front();
          if (out_modulus !== want.modulus) report("modulus", out_modulus, want.modulus);
          if (out_enc_exponent !== want.enc_exp) report("e", out_enc_exponent, want.enc_exp);
          if (out_dec_exponent !== want.dec_exp) report("d", out_dec_exponent, want.dec_exp);
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_last !== want.last) report("last", out_last, want.last);
        end
      end
    end
    pending_keys = key_q.size();
  end
endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rke_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic [IN_W-1:0] in_first_prime = '0;
  logic [IN_W-1:0] in_second_prime = '0;
  logic busy, out_valid, out_last;
  logic [OUT_W-1:0] out_modulus, out_enc_exponent, out_dec_exponent;
  status_t out_status;
  int fail_count, pending_keys, keys_seen;
  int requests;
  longint cycles = 0;

  int small_primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
  int mid_primes[] = '{101, 127, 211, 251, 257, 1009, 4093, 65521};

  rsa_key_pair_enumerator dut (.*);

  rke_checker chk (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_request(logic [IN_W-1:0] a, logic [IN_W-1:0] b, bit may_idle);
    if (may_idle && $urandom_range(99) < 21) begin
      start <= 1'b0;
      in_first_prime <= IN_W'($urandom);
      in_second_prime <= IN_W'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_first_prime <= a;
    in_second_prime <= b;
    do @(negedge clk); while (busy);
    @(posedge clk);
    requests++;
  endtask

  initial begin
    int sel;
    logic [IN_W-1:0] a, b;
    requests = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(0, 0, 1);
    send_request(1, 7, 1);
    send_request(7, 1, 1);
    send_request(13, 13, 1);
    send_request(2, 3, 1);
    send_request(3, 2, 1);
    send_request(2, 5, 1);
    send_request(5, 7, 1);
    send_request(65535, 65535, 1);
    send_request(65535, 3, 1);
    send_request(65521, 2, 1);
    send_request(251, 65521, 1);
    send_request(16'h8000, 16'h5555, 1);
    send_request(16'hAAAA, 17, 1);
    send_request(19, 29, 1);
    send_request(4, 9, 1);

    for (int i = 0; i < 84; i++) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        a = IN_W'(small_primes[$urandom_range(small_primes.size()-1)]);
        b = IN_W'(small_primes[$urandom_range(small_primes.size()-1)]);
      end else if (sel < 78) begin
        a = IN_W'(mid_primes[$urandom_range(mid_primes.size()-1)]);
        b = IN_W'(small_primes[$urandom_range(small_primes.size()-1)]);
      end else begin
        a = IN_W'($urandom);
        b = ($urandom_range(1)) ? IN_W'($urandom) : IN_W'(small_primes[$urandom_range(9)]);
      end
      send_request(a, b, !(i >= 40 && i < 60));
    end
    start <= 1'b0;

    while (pending_keys != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d requests sent, %0d key results checked", requests, keys_seen);
    $display("covered bad primes, equal primes, empty walks and full pair limits");
    if (fail_count == 0 && pending_keys == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rke_pkg.sv
hw/rtl/rke_div.sv
hw/rtl/rsa_key_pair_enumerator.sv
tb/rke_checker.sv
tb/tb.sv
